### design/ldrf_pkg.sv
// ----------------------------------------------------------------------------
// ldrf_pkg
// shared types and constants for the line depadding ring fifo
// ----------------------------------------------------------------------------
`default_nettype none

package ldrf_pkg;

   localparam int RING_BYTES_DEFAULT = 4096;

   localparam int BYTE_W  = 8;
   localparam int LINE_W  = 12;
   localparam int PAD_W   = 8;
   localparam int FILL_W  = 13;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 12;

   // request kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 2'd0,
      MODE_POP   = 2'd1,
      MODE_FLUSH = 2'd2
   } mode_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NO_LINE = 2'd2
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_A_W-1:0] {
      CSR_LINE_BYTES = 2'd0,
      CSR_PAD_BYTES  = 2'd1,
      CSR_INVERT     = 2'd2
   } csr_index_type;

   // result held in the output register, data byte comes from the ring read
   typedef struct packed {
      logic              data_valid;
      logic              line_end;
      status_type        status;
      logic [FILL_W-1:0] fill;
      logic              invert;
   } rsp_meta_type;

endpackage

`default_nettype wire

### design/ldrf_ram.sv
// ----------------------------------------------------------------------------
// ldrf_ram
// simple dual port byte ring storage, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ldrf_ram #(
   parameter int DEPTH  = ldrf_pkg::RING_BYTES_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [ldrf_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [ldrf_pkg::BYTE_W-1:0] rd_data
);
   import ldrf_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/line_depad_ring_fifo.sv
// ----------------------------------------------------------------------------
// line_depad_ring_fifo
// byte ring that takes raw scan bytes and hands back image lines without pad
// ----------------------------------------------------------------------------
// usage
//   req channel: one transfer is one command; req_tuser selects write, pop or
//   flush, req_tdata carries the byte to store on a write
//   rsp channel: exactly one transfer per command, in command order; tlast
//   marks the last data byte of a line, tuser gives out_valid and status
//   csr port: line_bytes, pad_bytes, invert_bits; user writes them only while idle, not enforced
//   a pop that starts a line is only served once a whole raw line (data plus pad) is held; after
//   the last data byte of a line the pad bytes are dropped in the same cycle
//   result: registered, on rsp in the cycle after its command's transfer
//   throughput: one command per cycle while rsp_tready stays high; pointers
//   and counts settle in the accept cycle, the byte comes out of the ring
//   ram's registered read port in the next one
//   stall: while a result waits on rsp, req_tready is low and nothing moves
//   reset: pointers, count and line state clear, registers go to line_bytes 1,
//   pad_bytes 0, no inversion; ring contents are left as they are
// ----------------------------------------------------------------------------
`default_nettype none

module line_depad_ring_fifo #(
   parameter int RING_BYTES = ldrf_pkg::RING_BYTES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // command channel
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [ldrf_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   input  wire logic [ldrf_pkg::MODE_W-1:0]  req_tuser,   // [1:0] mode
   // result channel
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [23:0]                  rsp_tdata,   // [7:0] out_byte, [20:8] fill_level
   output logic      [2:0]                   rsp_tuser,   // [0] out_valid, [2:1] status
   output logic                              rsp_tlast,   // line_end
   // configuration writes
   input  wire logic                         csr_wr_en,
   input  wire logic [ldrf_pkg::CSR_A_W-1:0] csr_addr,
   input  wire logic [ldrf_pkg::CSR_D_W-1:0] csr_wdata
);
   import ldrf_pkg::*;

   localparam int PW = $clog2(RING_BYTES);      // pointer bits
   localparam int CW = $clog2(RING_BYTES + 1);  // count bits, holds a full ring
   localparam logic [PW:0]   RING_P = (PW+1)'(RING_BYTES);
   localparam logic [CW-1:0] RING_C = CW'(RING_BYTES);

   // configuration
   logic [LINE_W-1:0] line_bytes_ff;
   logic [PAD_W-1:0]  pad_bytes_ff;
   logic              invert_ff;

   // ring state
   logic [PW-1:0]     wr_pos_ff, wr_pos_in;
   logic [PW-1:0]     rd_pos_ff, rd_pos_in;
   logic [CW-1:0]     held_ff, held_in;
   logic [LINE_W-1:0] progress_ff, progress_in;

   // result register
   logic              out_valid_ff;
   rsp_meta_type      meta_ff, meta_in;

   logic              req_fire;
   logic              is_write, is_pop;
   logic [LINE_W-1:0] lb;
   logic [FILL_W-1:0] need;
   logic              full;
   logic              can_pop;
   logic [CW-1:0]     held_dec;
   logic [LINE_W:0]   progress_inc;
   logic              line_done;
   logic [CW-1:0]     skip;
   logic [CW-1:0]     rd_step;
   logic [PW:0]       rd_sum;
   logic [PW:0]       wr_sum;
   logic [31:0]       fill_wide;
   logic              ram_wr_en, ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [BYTE_W-1:0] out_byte;

   // one result slot: take a command when the slot is empty or being drained
   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign is_write = req_tuser == MODE_WRITE;
   assign is_pop   = req_tuser == MODE_POP;

   // zero line length behaves as one
   assign lb   = (line_bytes_ff == '0) ? LINE_W'(1) : line_bytes_ff;
   assign need = FILL_W'(lb) + FILL_W'(pad_bytes_ff);
   assign full = held_ff == RING_C;

   // a fresh line needs the whole raw line present, an open one any byte
   assign can_pop = (progress_ff == '0) ? (32'(held_ff) >= 32'(need))
                                        : (held_ff != '0);

   assign held_dec     = held_ff - CW'(1);
   assign progress_inc = (LINE_W+1)'(progress_ff) + (LINE_W+1)'(1);
   assign line_done    = progress_inc >= (LINE_W+1)'(lb);

   // pad skip is bounded by what is left in the ring
   assign skip    = (32'(pad_bytes_ff) < 32'(held_dec)) ? CW'(pad_bytes_ff) : held_dec;
   assign rd_step = line_done ? (skip + CW'(1)) : CW'(1);
   // step never exceeds the held count, so one wrap correction is enough
   assign rd_sum  = (PW+1)'(rd_pos_ff) + (PW+1)'(rd_step);
   assign wr_sum  = (PW+1)'(wr_pos_ff) + (PW+1)'(1);

   assign ram_wr_en = req_fire && is_write && !full;
   assign ram_rd_en = req_fire && is_pop && can_pop;

   // next state of pointers, count and line progress
   always_comb begin
      wr_pos_in   = wr_pos_ff;
      rd_pos_in   = rd_pos_ff;
      held_in     = held_ff;
      progress_in = progress_ff;
      meta_in     = meta_ff;
      if (req_fire) begin
         meta_in.data_valid = 1'b0;
         meta_in.line_end   = 1'b0;
         meta_in.status     = STATUS_OK;
         meta_in.invert     = invert_ff;
         case (req_tuser)
            MODE_WRITE: begin
               if (full) begin
                  meta_in.status = STATUS_FULL;
               end else begin
                  wr_pos_in = (wr_sum == RING_P) ? '0 : wr_sum[PW-1:0];
                  held_in   = held_ff + CW'(1);
               end
            end
            MODE_POP: begin
               if (!can_pop) begin
                  meta_in.status = STATUS_NO_LINE;
               end else begin
                  meta_in.data_valid = 1'b1;
                  rd_pos_in = (rd_sum >= RING_P) ? PW'(rd_sum - RING_P) : rd_sum[PW-1:0];
                  if (line_done) begin
                     held_in          = held_dec - skip;
                     progress_in      = '0;
                     meta_in.line_end = 1'b1;
                  end else begin
                     held_in     = held_dec;
                     progress_in = progress_inc[LINE_W-1:0];
                  end
               end
            end
            MODE_FLUSH: begin
               rd_pos_in   = wr_pos_ff;
               held_in     = '0;
               progress_in = '0;
            end
            default: begin
               // unused code, nothing changes
            end
         endcase
         meta_in.fill = fill_wide[FILL_W-1:0];
      end
   end

   assign fill_wide = 32'(held_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff   <= '0;
         rd_pos_ff   <= '0;
         held_ff     <= '0;
         progress_ff <= '0;
      end else begin
         wr_pos_ff   <= wr_pos_in;
         rd_pos_ff   <= rd_pos_in;
         held_ff     <= held_in;
         progress_ff <= progress_in;
      end
   end

   // result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
   end

   // configuration writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff <= LINE_W'(1);
         pad_bytes_ff  <= '0;
         invert_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_LINE_BYTES: line_bytes_ff <= csr_wdata[LINE_W-1:0];
            CSR_PAD_BYTES:  pad_bytes_ff  <= csr_wdata[PAD_W-1:0];
            CSR_INVERT:     invert_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ldrf_ram #(
      .DEPTH  (RING_BYTES),
      .ADDR_W (PW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_pos_ff),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_pos_ff),
      .rd_data (ram_rd_data)
   );

   // ram read data holds while the slot stalls, since no pop is taken then
   assign out_byte = !meta_ff.data_valid ? '0
                   : (meta_ff.invert ? ~ram_rd_data : ram_rd_data);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, meta_ff.fill, out_byte};
   assign rsp_tuser  = {meta_ff.status, meta_ff.data_valid};
   assign rsp_tlast  = meta_ff.line_end;

   // ---------------------------------------------------------------- checks

   // held count never exceeds the ring
   assert property (@(posedge clock) disable iff (reset) held_ff <= RING_C)
      else $error("held count beyond ring size");

   // pointers and held count agree modulo the ring size
   assert property (@(posedge clock) disable iff (reset)
      (held_ff == RING_C) ||
      (((wr_pos_ff >= rd_pos_ff) ? (32'(wr_pos_ff) - 32'(rd_pos_ff))
                                 : (32'(wr_pos_ff) + RING_BYTES - 32'(rd_pos_ff)))
       == 32'(held_ff)))
      else $error("ring pointers disagree with held count");

   // a served pop shows a data byte in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (rsp_tvalid && meta_ff.data_valid && meta_ff.status == STATUS_OK))
      else $error("served pop lost its data flag");

   // a refused write leaves the ring untouched
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_write && full) |=> (held_ff == RING_C && $stable(wr_pos_ff)))
      else $error("refused write changed ring state");

endmodule

`default_nettype wire
